FILE: src/max_heap_priority_queue_macros.svh
// Assertion helpers, clocked on i_clk and quiet during reset.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define MHPQ_ASSERT_STEP(label, cond, nxt, msg) \
    `MHPQ_ASSERT(label, (cond) |=> (nxt), msg)

`endif

FILE: src/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 255;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = ADDR_W;
    localparam int KID_W    = ADDR_W + 1;
    localparam int FILL_W   = 8;

    localparam logic MODE_INS = 1'b0;
    localparam logic MODE_POP = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        logic mode;
        t_key in_key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        t_key              out_key;
        logic [FILL_W-1:0] fill_count;
    } t_out_item;

endpackage

FILE: src/max_heap_priority_queue.sv
// Binary max heap of signed keys held in one dual-read, single-write synchronous RAM.
// Busy while an insert climbs the new key toward the root or a removal sifts the last entry
// down from the root; a compare can end either walk early. At 255 slots a walk spans at most 7 levels.
// Rejected operations (empty / full) never raise busy; their result follows next cycle.
// Synchronous active-low reset empties the heap; RAM contents are not cleared.
`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  mhpq_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_valid,
    output mhpq_pkg::t_out_item  o_result
);
    import mhpq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_TOP    = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;

    t_key heap_mem [0:CAPACITY];

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [KID_W-1:0]  r_kid, n_kid;
    t_key              r_key, n_key;
    t_key              r_top, n_top;
    logic              r_valid, n_valid;
    t_out_item         r_result, n_result;
    t_key              r_rd_a, r_rd_b;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra, mem_rb;
    t_key              mem_wd;

    logic              fin;
    logic [1:0]        fin_status;
    logic [KID_W-1:0]  kid_p1, cidx;
    logic              take_r;
    t_key              child;

    assign kid_p1 = r_kid + KID_W'(1);
    assign take_r = (r_kid < KID_W'(r_count)) && (r_rd_a < r_rd_b);
    assign child  = take_r ? r_rd_b : r_rd_a;
    assign cidx   = take_r ? kid_p1 : r_kid;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_kid      = r_kid;
        n_key      = r_key;
        n_top      = r_top;
        mem_we     = 1'b0;
        mem_wa     = r_pos;
        mem_wd     = r_key;
        mem_ra     = '0;
        mem_rb     = '0;
        fin        = 1'b0;
        fin_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.mode == MODE_INS) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                        end else begin
                            n_key   = i_item.in_key;
                            n_count = r_count + CNT_W'(1);
                            n_pos   = ADDR_W'(r_count + CNT_W'(1));
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            // root and last entry fetched together
                            mem_ra  = ADDR_W'(1);
                            mem_rb  = ADDR_W'(r_count);
                            n_count = r_count - CNT_W'(1);
                            n_state = S_TOP;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == ADDR_W'(1)) begin
                    mem_we = 1'b1;
                    fin    = 1'b1;
                end else begin
                    mem_ra  = r_pos >> 1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key > r_rd_a) begin
                    mem_wd  = r_rd_a;
                    n_pos   = r_pos >> 1;
                    n_state = S_UP_RD;
                end else begin
                    fin = 1'b1;
                end
            end
            S_TOP: begin
                n_top   = r_rd_a;
                n_key   = r_rd_b;
                n_pos   = ADDR_W'(1);
                n_kid   = KID_W'(2);
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (r_kid <= KID_W'(r_count)) begin
                    mem_ra  = r_kid[ADDR_W-1:0];
                    mem_rb  = kid_p1[ADDR_W-1:0];
                    n_state = S_DN_CMP;
                end else begin
                    mem_we = 1'b1;
                    fin    = 1'b1;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_key >= child) begin
                    fin = 1'b1;
                end else begin
                    mem_wd  = child;
                    n_pos   = cidx[ADDR_W-1:0];
                    n_kid   = {cidx[ADDR_W-1:0], 1'b0};
                    n_state = S_DN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_valid             = fin;
        n_result            = r_result;
        n_result.status     = fin_status;
        n_result.fill_count = FILL_W'(r_count);
        n_result.out_key    = (fin_status == ST_OK && r_state != S_UP_RD &&
                               r_state != S_UP_CMP) ? r_top : '0;
        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            heap_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= heap_mem[mem_ra];
        r_rd_b <= heap_mem[mem_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_kid    <= n_kid;
        r_key    <= n_key;
        r_top    <= n_top;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `MHPQ_ASSERT(a_count_cap, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `MHPQ_ASSERT_STEP(a_accept_busy, start && !busy && ((i_item.mode == MODE_INS && r_count != CNT_W'(CAPACITY)) || (i_item.mode == MODE_POP && r_count != '0)), busy, "valid operation did not start")
    `MHPQ_ASSERT(a_err_stable, (o_valid && o_result.status != ST_OK) |-> $stable(r_count), "rejected operation changed count")
    `MHPQ_ASSERT(a_err_zero, (o_valid && o_result.status != ST_OK) |-> (o_result.out_key == '0), "rejected operation returned a key")

endmodule

FILE: test/max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;

    import mhpq_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 30;
    localparam int DIR_ROWS    = 25;

    localparam t_key KEY_MAX = 32'sh7fff_ffff;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic      mode;
        t_key      key;
        logic      fixed;   // expected result typed in below
        t_out_item res;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    // shadow heap, one-based like the block
    t_key      shadow_heap [0:CAPACITY];
    int        shadow_count;
    t_out_item pending_results [$];
    int        err_cnt;
    int        cycle_cnt;
    bit        no_idle;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{MODE_POP, 32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 8'd0}},
        '{MODE_INS, KEY_MAX,         1'b1, '{ST_OK,    32'sd0, 8'd1}},
        '{MODE_INS, KEY_MIN,         1'b1, '{ST_OK,    32'sd0, 8'd2}},
        '{MODE_POP, 32'sd0,          1'b1, '{ST_OK,    KEY_MAX, 8'd1}},
        '{MODE_POP, 32'sd0,          1'b1, '{ST_OK,    KEY_MIN, 8'd0}},
        '{MODE_POP, -32'sd1,         1'b1, '{ST_EMPTY, 32'sd0, 8'd0}},
        '{MODE_INS, 32'sd5,          1'b0, '0},
        '{MODE_INS, 32'sd5,          1'b0, '0},
        '{MODE_INS, -32'sd1,         1'b0, '0},
        '{MODE_INS, 32'sd0,          1'b0, '0},
        '{MODE_INS, 32'sd7,          1'b0, '0},
        '{MODE_INS, 32'sd5,          1'b0, '0},
        '{MODE_INS, 32'sh5555_5555,  1'b0, '0},
        '{MODE_INS, 32'shaaaa_aaaa,  1'b0, '0},
        '{MODE_INS, 32'sd3,          1'b0, '0},
        '{MODE_POP, -32'sd1,         1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, KEY_MAX,         1'b0, '0},
        '{MODE_INS, 32'sd6,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0},
        '{MODE_POP, 32'sd0,          1'b0, '0}
    };

    max_heap_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // applies one operation to the shadow heap and returns what the block should give
    function automatic t_out_item heap_apply(t_in_item it);
        t_out_item r;
        t_key      moved;
        int        pos;
        int        hole;
        int        kid;
        r = '0;
        r.status = ST_OK;
        if (it.mode == MODE_INS) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                shadow_count++;
                pos = shadow_count;
                while (pos != 1 && it.in_key > shadow_heap[pos / 2]) begin
                    shadow_heap[pos] = shadow_heap[pos / 2];
                    pos = pos / 2;
                end
                shadow_heap[pos] = it.in_key;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.out_key = shadow_heap[1];
                moved = shadow_heap[shadow_count];
                hole = 1;
                kid = 2;
                shadow_count--;
                while (kid <= shadow_count) begin
                    // left child wins a tie
                    if (kid < shadow_count && shadow_heap[kid] < shadow_heap[kid + 1])
                        kid++;
                    if (moved >= shadow_heap[kid])
                        break;
                    shadow_heap[hole] = shadow_heap[kid];
                    hole = kid;
                    kid = kid * 2;
                end
                shadow_heap[hole] = moved;
            end
        end
        r.fill_count = shadow_count[FILL_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    function automatic t_key pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end else if (r <= 3) begin
            // narrow range so that equal keys meet in the tree
            return t_key'(int'($urandom_range(0, 16)) - 8);
        end
        return t_key'($urandom);
    endfunction

    // one command transfer; prediction is taken at the accepting edge
    task automatic send_op(logic mode, t_key key, logic fixed, t_out_item fixed_res);
        int        gap;
        t_in_item  it;
        t_out_item want;
        gap = pick_gap();
        it.mode = mode;
        it.in_key = key;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        want = heap_apply(it);
        pending_results.push_back(fixed ? fixed_res : want);
    endtask

    task automatic send_rand(int ins_pct);
        logic mode;
        mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INS : MODE_POP;
        send_op(mode, pick_key(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %p", o_result));
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_result.status, want.status));
                if (o_result.out_key !== want.out_key)
                    flag_mismatch($sformatf("out_key %0d, want %0d",
                                            o_result.out_key, want.out_key));
                if (o_result.fill_count !== want.fill_count)
                    flag_mismatch($sformatf("fill_count %0d, want %0d",
                                            o_result.fill_count, want.fill_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        no_idle = 1'b0;
        shadow_count = 0;
        for (int i = 0; i <= CAPACITY; i++)
            shadow_heap[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_op(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].fixed, dir_rows[i].res);

        // mixed traffic, growing
        for (int i = 0; i < 20; i++) begin
            if (i % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_rand(60);
        end

        // fill to capacity, then knock on the full heap
        no_idle = 1'b0;
        while (shadow_count < CAPACITY) begin
            if (shadow_count % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            send_op(MODE_INS, pick_key(), 1'b0, '0);
        end
        for (int i = 0; i < 4; i++)
            send_op(MODE_INS, pick_key(), 1'b0, '0);
        for (int i = 0; i < 10; i++)
            send_op((i % 2) ? MODE_INS : MODE_POP, pick_key(), 1'b0, '0);

        // drain, mostly removals, then over-pop
        while (shadow_count > 0) begin
            if (shadow_count % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            send_rand(3);
        end
        no_idle = 1'b0;
        for (int i = 0; i < 3; i++)
            send_op(MODE_POP, pick_key(), 1'b0, '0);

        for (int i = 0; i < 10; i++)
            send_rand(50);

        @(negedge i_clk);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
